// ===== design/vrc_pkg.sv =====
package vrc_pkg;

  localparam int SAMPLE_W = 32;
  localparam int THR_W    = 31;
  localparam int CHAN_W   = 8;
  localparam int DEN_W    = THR_W + 1;
  // The largest numerator is 510 times the threshold, which stays below 2**40.
  localparam int REM_W    = 40;
  localparam int W_W      = 36;
  localparam int COEF_W   = 13;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [THR_W-1:0] THRESH_RESET = THR_W'(65536);

  // Register index, taken from the word address.
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_MODE      = 1'b1;

  typedef enum logic [1:0] {
    MODE_HEAT    = 2'd0,
    MODE_RGB     = 2'd1,
    MODE_BW      = 2'd2,
    MODE_UNKNOWN = 2'd3
  } mode_t;

  // How the quotient of the divider chain turns into the three channels.
  typedef enum logic [3:0] {
    TAG_HEAT_DARK_BLUE = 4'd0,
    TAG_HEAT_BLUE      = 4'd1,
    TAG_HEAT_CYAN      = 4'd2,
    TAG_HEAT_YELLOW    = 4'd3,
    TAG_HEAT_RED       = 4'd4,
    TAG_RGB_BLACK      = 4'd5,
    TAG_RGB_SAT        = 4'd6,
    TAG_RGB_HIGH       = 4'd7,
    TAG_RGB_MID        = 4'd8,
    TAG_RGB_LOW        = 4'd9,
    TAG_BW             = 4'd10,
    TAG_BAD            = 4'd11
  } tag_t;

  // Numerator is 255*w + coef*thr, the divisor is 2*thr.
  typedef struct packed {
    logic signed [W_W-1:0]    w;
    logic signed [COEF_W-1:0] coef;
    logic [THR_W-1:0]         thr;
    tag_t                     tag;
  } prep_beat_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [CHAN_W-1:0] quo;
    logic [DEN_W-1:0]  den;
    tag_t              tag;
  } div_beat_t;

endpackage

// ===== design/vrc_prep.sv =====
module vrc_prep (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [vrc_pkg::SAMPLE_W-1:0]     sample_value,
  input  logic [vrc_pkg::THR_W-1:0]        threshold,
  input  vrc_pkg::mode_t                   map_mode,
  output logic                             out_valid,
  input  logic                             out_ready,
  output vrc_pkg::div_beat_t               out_beat
);
  import vrc_pkg::*;

  localparam logic signed [COEF_W-1:0] C_ZERO = COEF_W'(0);
  localparam logic signed [COEF_W-1:0] C_P255 = COEF_W'(255);
  localparam logic signed [COEF_W-1:0] C_M255 = -COEF_W'(255);
  localparam logic signed [COEF_W-1:0] C_M765 = -COEF_W'(765);
  localparam logic signed [COEF_W-1:0] C_P1785 = COEF_W'(1785);
  localparam logic signed [COEF_W-1:0] C_P2295 = COEF_W'(2295);
  localparam logic signed [COEF_W-1:0] C_M1020 = -COEF_W'(1020);
  localparam logic signed [COEF_W-1:0] C_M510 = -COEF_W'(510);

  logic             a_valid;
  logic             b_valid;
  logic             a_load;
  logic             b_load;
  prep_beat_t       a_beat;
  prep_beat_t       a_next;
  div_beat_t        b_next;

  logic [THR_W-1:0] t;
  logic             neg;
  logic             over;
  logic [THR_W-1:0] vc;
  logic [THR_W+2:0] e8;
  logic [THR_W+2:0] u;
  logic [THR_W+2:0] t1;
  logic [THR_W+2:0] t2;
  logic [THR_W+2:0] t3;
  logic [THR_W+2:0] t4;
  logic [THR_W+2:0] t5;
  logic [THR_W+2:0] t6;
  logic [THR_W+2:0] t7;
  logic [THR_W-1:0] diff;

  logic signed [W_W+8:0] wx;
  logic signed [W_W+8:0] p;
  logic signed [W_W+8:0] ct;
  logic signed [W_W+8:0] num;

  assign b_load   = !b_valid || out_ready;
  assign a_load   = !a_valid || b_load;
  assign in_ready = a_load;
  assign out_valid = b_valid;

  // First stage: clamp, find the segment, pick the linear ramp.
  always_comb begin
    t    = (threshold == '0) ? THR_W'(1) : threshold;
    neg  = sample_value[SAMPLE_W-1];
    over = !neg && (sample_value[THR_W-1:0] > t);
    vc   = neg ? '0 : (over ? t : sample_value[THR_W-1:0]);
    e8   = {vc, 3'b000};
    u    = {3'b000, sample_value[THR_W-1:0]};
    t1   = {3'b000, t};
    t2   = t1 << 1;
    t4   = t1 << 2;
    t3   = t1 + t2;
    t5   = t1 + t4;
    t6   = t2 + t4;
    t7   = (t1 << 3) - t1;
    diff = t - vc;

    a_next.thr  = t;
    a_next.w    = '0;
    a_next.coef = C_ZERO;
    a_next.tag  = TAG_BAD;
    unique case (map_mode)
      MODE_HEAT: begin
        if (e8 < t1) begin
          a_next.w    = $signed({2'b00, e8});
          a_next.coef = C_P255;
          a_next.tag  = TAG_HEAT_DARK_BLUE;
        end else if (e8 < t3) begin
          a_next.w    = $signed({2'b00, e8});
          a_next.coef = C_M255;
          a_next.tag  = TAG_HEAT_BLUE;
        end else if (e8 < t5) begin
          a_next.w    = $signed({2'b00, e8});
          a_next.coef = C_M765;
          a_next.tag  = TAG_HEAT_CYAN;
        end else if (e8 < t7) begin
          a_next.w    = -$signed({2'b00, e8});
          a_next.coef = C_P1785;
          a_next.tag  = TAG_HEAT_YELLOW;
        end else begin
          a_next.w    = -$signed({2'b00, e8});
          a_next.coef = C_P2295;
          a_next.tag  = TAG_HEAT_RED;
        end
      end
      MODE_RGB: begin
        if (neg) begin
          a_next.tag = TAG_RGB_BLACK;
        end else if (u >= t6) begin
          a_next.tag = TAG_RGB_SAT;
        end else if (u >= t4) begin
          a_next.w    = $signed({2'b00, u});
          a_next.coef = C_M1020;
          a_next.tag  = TAG_RGB_HIGH;
        end else if (u >= t2) begin
          a_next.w    = $signed({2'b00, u});
          a_next.coef = C_M510;
          a_next.tag  = TAG_RGB_MID;
        end else begin
          a_next.w   = $signed({2'b00, u});
          a_next.tag = TAG_RGB_LOW;
        end
      end
      MODE_BW: begin
        // 255*(t-v)/t is computed as 510*(t-v) over 2t like the other ramps.
        a_next.w   = $signed({4'b0000, diff, 1'b0});
        a_next.tag = TAG_BW;
      end
      MODE_UNKNOWN: begin
        a_next.tag = TAG_BAD;
      end
    endcase
  end

  // Second stage: form the numerator and the divisor.
  always_comb begin
    wx  = (W_W+9)'(a_beat.w);
    p   = (wx <<< 8) - wx;
    ct  = a_beat.coef * $signed({1'b0, a_beat.thr});
    num = p + ct;
    b_next.rem = num[REM_W-1:0];
    b_next.quo = '0;
    b_next.den = {a_beat.thr, 1'b0};
    b_next.tag = a_beat.tag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (a_load) begin
        a_valid <= in_valid;
      end
      if (b_load) begin
        b_valid <= a_valid;
      end
    end
    if (a_load && in_valid) begin
      a_beat <= a_next;
    end
    if (b_load && a_valid) begin
      out_beat <= b_next;
    end
  end

endmodule

// ===== design/vrc_div_cell.sv =====
module vrc_div_cell #(
  parameter int unsigned BIT = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  vrc_pkg::div_beat_t  in_beat,
  output logic                out_valid,
  input  logic                out_ready,
  output vrc_pkg::div_beat_t  out_beat
);
  import vrc_pkg::*;

  logic [REM_W:0] trial;
  div_beat_t      beat_next;

  assign in_ready = !out_valid || out_ready;

  // One restoring step: try the divisor shifted to this quotient bit.
  always_comb begin
    beat_next = in_beat;
    trial = {1'b0, in_beat.rem} - ((REM_W+1)'(in_beat.den) << BIT);
    if (!trial[REM_W]) begin
      beat_next.rem = trial[REM_W-1:0];
      beat_next.quo = in_beat.quo | (CHAN_W'(1) << BIT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_beat <= beat_next;
    end
  end

endmodule

// ===== design/value_to_rgb_colormap.sv =====
// Channel   Handshake                     Payload
// input     in_valid / in_ready           sample_value[31:0] (signed)
// output    out_valid / out_ready         red[7:0], green[7:0], blue[7:0], bad_mode
// config    psel/penable/pwrite/pready    paddr[2:0], pwdata[31:0], prdata[31:0]
//
// One beat per cycle is taken and delivered while out_ready is high; an accepted beat
// passes the second setup stage and the eight cells into the output register.
// Most of the pipeline is the eight-cell restoring divider, one quotient bit a cell.
// Reset empties every stage and loads threshold 1.0 and the heatmap mode.
// With out_ready low the output holds, empty stages still fill, and in_ready
// drops only once every stage is full.
module value_to_rgb_colormap (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] sample_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic        bad_mode,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import vrc_pkg::*;

  logic [THR_W-1:0] threshold;
  logic [1:0]       map_mode;
  logic             cfg_write;

  logic             chain_valid [CHAN_W+1];
  logic             chain_ready [CHAN_W+1];
  div_beat_t        chain_beat  [CHAN_W+1];

  div_beat_t        last;
  logic             nz;
  logic [CHAN_W-1:0] q;
  logic [CHAN_W-1:0] red_next;
  logic [CHAN_W-1:0] green_next;
  logic [CHAN_W-1:0] blue_next;
  logic             bad_next;
  logic             o_load;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESH_RESET;
      map_mode  <= MODE_HEAT;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_THRESHOLD: threshold <= pwdata[THR_W-1:0];
        REG_MODE:      map_mode  <= pwdata[1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_THRESHOLD: prdata = {{(DATA_W-THR_W){1'b0}}, threshold};
      REG_MODE:      prdata = {{(DATA_W-2){1'b0}}, map_mode};
    endcase
  end

  vrc_prep u_prep (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample_value (sample_value),
    .threshold    (threshold),
    .map_mode     (mode_t'(map_mode)),
    .out_valid    (chain_valid[0]),
    .out_ready    (chain_ready[0]),
    .out_beat     (chain_beat[0])
  );

  // Cell k settles quotient bit CHAN_W-1-k, most significant first.
  for (genvar k = 0; k < CHAN_W; k++) begin : g_cell
    vrc_div_cell #(
      .BIT (CHAN_W - 1 - k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[k]),
      .in_ready  (chain_ready[k]),
      .in_beat   (chain_beat[k]),
      .out_valid (chain_valid[k+1]),
      .out_ready (chain_ready[k+1]),
      .out_beat  (chain_beat[k+1])
    );
  end

  assign o_load             = !out_valid || out_ready;
  assign chain_ready[CHAN_W] = o_load;
  assign last               = chain_beat[CHAN_W];
  assign q                  = last.quo;
  assign nz                 = |last.rem;

  always_comb begin
    red_next   = '0;
    green_next = '0;
    blue_next  = '0;
    bad_next   = 1'b0;
    case (last.tag)
      TAG_HEAT_DARK_BLUE: blue_next = q;
      TAG_HEAT_BLUE: begin
        green_next = q;
        blue_next  = 8'd255;
      end
      TAG_HEAT_CYAN: begin
        // The falling blue ramp is 255 minus the rising red ramp, rounded up.
        red_next   = q;
        green_next = 8'd255;
        blue_next  = 8'd255 - q - {7'b0, nz};
      end
      TAG_HEAT_YELLOW: begin
        red_next   = 8'd255;
        green_next = q;
      end
      TAG_HEAT_RED:  red_next = q;
      TAG_RGB_BLACK: red_next = '0;
      TAG_RGB_SAT:   red_next = 8'd255;
      TAG_RGB_HIGH: begin
        red_next   = q;
        green_next = 8'd255 - q;
      end
      TAG_RGB_MID: begin
        green_next = q;
        blue_next  = 8'd255 - q;
      end
      TAG_RGB_LOW: blue_next = q;
      TAG_BW: begin
        red_next   = q;
        green_next = q;
        blue_next  = q;
      end
      TAG_BAD: bad_next = 1'b1;
      default: bad_next = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_load) begin
      out_valid <= chain_valid[CHAN_W];
    end
    if (o_load && chain_valid[CHAN_W]) begin
      red      <= red_next;
      green    <= green_next;
      blue     <= blue_next;
      bad_mode <= bad_next;
    end
  end

`ifndef SYNTHESIS
  a_bad_is_black: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_mode |-> red == '0 && green == '0 && blue == '0)
    else $error("unknown mode beat carries a color");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while the output is free");

  a_div_remainder: assert property (@(posedge clk) disable iff (rst)
    chain_valid[CHAN_W] |-> last.rem < REM_W'(last.den))
    else $error("divider remainder not below the divisor");
`endif

endmodule

// ===== dv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import vrc_pkg::*;

  localparam logic [ADDR_W-1:0] ADDR_THRESHOLD = {REG_THRESHOLD, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_MODE      = {REG_MODE, 2'b00};
  localparam int PIPE_DEPTH  = 11;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PRINT_LIMIT = 100;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              bad;
  } pixel_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    pixel_t              color;
  } pending_t;

  class color_scoreboard;
    logic [THR_W-1:0] thr;
    mode_t            mode;
    pending_t         pending[$];
    int               errors;

    function new();
      thr = THRESH_RESET;
      mode = MODE_HEAT;
      errors = 0;
    endfunction

    function void set_register(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
      if (addr == ADDR_THRESHOLD) begin
        thr = data[THR_W-1:0];
      end else if (addr == ADDR_MODE) begin
        mode = mode_t'(data[1:0]);
      end
    endfunction

    // Exact floor of each channel ramp, worked out on 64-bit integers.
    function pixel_t map_color(logic [SAMPLE_W-1:0] raw);
      longint v;
      u64_t   t, den, cv, e8, s, u, r, g, b;
      pixel_t p;
      v = longint'($signed(raw));
      t = (thr == 0) ? 1 : u64_t'(thr);
      den = 2 * t;
      cv = (v < 0) ? 0 : u64_t'(v);
      if (cv > t) begin
        cv = t;
      end
      r = 0;
      g = 0;
      b = 0;
      p.bad = 1'b0;
      case (mode)
        MODE_HEAT: begin
          e8 = 8 * cv;
          s = 255 * e8;
          if (e8 < t) begin
            b = (255 * t + s) / den;
          end else if (e8 < 3 * t) begin
            b = 255;
            g = (s - 255 * t) / den;
          end else if (e8 < 5 * t) begin
            g = 255;
            r = (s - 765 * t) / den;
            b = (1275 * t - s) / den;
          end else if (e8 < 7 * t) begin
            r = 255;
            g = (1785 * t - s) / den;
          end else begin
            r = (2295 * t - s) / den;
          end
        end
        MODE_RGB: begin
          if (v >= 0) begin
            u = u64_t'(v);
            if (u >= 6 * t) begin
              r = 255;
            end else if (u >= 4 * t) begin
              r = (255 * u - 1020 * t) / den;
              g = 255 - r;
            end else if (u >= 2 * t) begin
              g = (255 * u - 510 * t) / den;
              b = 255 - g;
            end else begin
              b = (255 * u) / den;
            end
          end
        end
        MODE_BW: begin
          r = (255 * (t - cv)) / t;
          g = r;
          b = r;
        end
        default: begin
          p.bad = 1'b1;
        end
      endcase
      p.red = r[CHAN_W-1:0];
      p.green = g[CHAN_W-1:0];
      p.blue = b[CHAN_W-1:0];
      return p;
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] raw);
      pending_t e;
      e.sample = raw;
      e.color = map_color(raw);
      pending.push_back(e);
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= PRINT_LIMIT) begin
        $display("%0t MISMATCH: %s", $realtime, what);
      end
    endtask

    task check_pixel(pixel_t got);
      pending_t e;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected output beat r=%0d g=%0d b=%0d bad=%0b",
                                  got.red, got.green, got.blue, got.bad));
        return;
      end
      e = pending.pop_front();
      if (got.red !== e.color.red) begin
        report_mismatch($sformatf("sample %h red %0d, want %0d", e.sample, got.red,
                                  e.color.red));
      end
      if (got.green !== e.color.green) begin
        report_mismatch($sformatf("sample %h green %0d, want %0d", e.sample, got.green,
                                  e.color.green));
      end
      if (got.blue !== e.color.blue) begin
        report_mismatch($sformatf("sample %h blue %0d, want %0d", e.sample, got.blue,
                                  e.color.blue));
      end
      if (got.bad !== e.color.bad) begin
        report_mismatch($sformatf("sample %h bad_mode %0b, want %0b", e.sample, got.bad,
                                  e.color.bad));
      end
    endtask

    task flush_leftovers();
      pending_t e;
      while (pending.size() != 0) begin
        e = pending.pop_front();
        report_mismatch($sformatf("no output beat for sample %h", e.sample));
      end
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [SAMPLE_W-1:0] sample_value = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [CHAN_W-1:0]   red;
  logic [CHAN_W-1:0]   green;
  logic [CHAN_W-1:0]   blue;
  logic                bad_mode;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  color_scoreboard sb = new();
  bit stall_on = 1'b0;
  int cycles = 0;

  value_to_rgb_colormap dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample_value (sample_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .bad_mode     (bad_mode),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        sb.note_sample(sample_value);
      end
      if (out_valid && out_ready) begin
        sb.check_pixel('{red: red, green: green, blue: blue, bad: bad_mode});
      end
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else if (!stall_on || $urandom_range(0, 99) >= 25) begin
        out_ready = 1'b1;
      end else begin
        out_ready = 1'b0;
        hold = pick_gap() - 1;
      end
    end
  end

  // Some samples cluster around the ramp breakpoints of the current threshold; the rest are random, spread, or corners.
  function automatic logic [SAMPLE_W-1:0] pick_sample(u64_t t);
    int     sel;
    longint val;
    sel = $urandom_range(0, 99);
    if (sel < 20) begin
      return $urandom();
    end else if (sel < 50) begin
      val = longint'(($urandom_range(0, 50) * t) / 8) + longint'($urandom_range(0, 4)) - 2;
    end else if (sel < 90) begin
      val = longint'((t * $urandom_range(0, 7000)) / 1000);
      if (sel >= 85) begin
        val = -val;
      end
    end else begin
      case ($urandom_range(0, 4))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'hFFFF_FFFF;
        3: return 32'h0000_0001;
        default: return 32'h0000_0000;
      endcase
    end
    if (val > 64'sh7FFF_FFFF) begin
      val = 64'sh7FFF_FFFF;
    end else if (val < -64'sh8000_0000) begin
      val = -64'sh8000_0000;
    end
    return val[SAMPLE_W-1:0];
  endfunction

  // Called and returns at a falling edge; valid stays high between back-to-back beats.
  task send_sample(logic [SAMPLE_W-1:0] v);
    if (stall_on && $urandom_range(0, 99) < 25) begin
      in_valid = 1'b0;
      repeat (pick_gap()) @(negedge clk);
    end
    in_valid = 1'b1;
    sample_value = v;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task write_reg(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_register(addr, data);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task settle();
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  initial begin
    logic [SAMPLE_W-1:0] heat_points[$];
    logic [SAMPLE_W-1:0] rgb_points[$];
    logic [SAMPLE_W-1:0] bw_points[$];
    logic [DATA_W-1:0]   thr_word;
    mode_t               mode_sel;
    u64_t                t;
    int                  n;

    heat_points = '{32'h8000_0000, 32'hFFFF_FFFF, 0, 1, 8191, 8192, 24575, 24576,
                    40960, 57344, 65535, 65536, 65537, 32'h7FFF_FFFF};
    rgb_points = '{32'hFFFF_FFFF, 0, 131071, 131072, 262144, 393215, 393216,
                   32'h7FFF_FFFF};
    bw_points = '{0, 32768, 65536};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    stall_on = 1'b1;

    // Directed beats, the first ones under the reset settings.
    foreach (heat_points[i]) send_sample(heat_points[i]);
    settle();
    write_reg(ADDR_MODE, {{(DATA_W-2){1'b0}}, MODE_RGB});
    foreach (rgb_points[i]) send_sample(rgb_points[i]);
    settle();
    write_reg(ADDR_MODE, {{(DATA_W-2){1'b0}}, MODE_BW});
    foreach (bw_points[i]) send_sample(bw_points[i]);
    settle();
    write_reg(ADDR_MODE, {{(DATA_W-2){1'b0}}, MODE_UNKNOWN});
    send_sample(32'd12345);
    settle();
    // A zero threshold behaves as one LSB.
    write_reg(ADDR_THRESHOLD, 0);
    write_reg(ADDR_MODE, {{(DATA_W-2){1'b0}}, MODE_HEAT});
    send_sample(0);
    send_sample(1);

    for (int p = 0; p < 14; p++) begin
      case (p)
        0: thr_word = 1;
        1: thr_word = 0;
        2: thr_word = 32'h7FFF_FFFF;
        3: thr_word = 32'hFFFF_FFFF;
        4: thr_word = 65536;
        5: thr_word = $urandom_range(2, 64);
        6: thr_word = $urandom_range(65, 1 << 20);
        default: thr_word = (p % 2 != 0) ? $urandom() : $urandom_range(2, 1 << 24);
      endcase
      mode_sel = mode_t'(p % 4);
      settle();
      write_reg(ADDR_THRESHOLD, thr_word);
      write_reg(ADDR_MODE, {{(DATA_W-2){1'b0}}, mode_sel});
      stall_on = (p % 3 != 2);
      n = (mode_sel == MODE_UNKNOWN) ? 20 : 90;
      t = (thr_word[THR_W-1:0] == 0) ? 1 : u64_t'(thr_word[THR_W-1:0]);
      repeat (n) send_sample(pick_sample(t));
    end

    settle();
    repeat (PIPE_DEPTH) @(negedge clk);
    sb.flush_leftovers();
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== value_to_rgb_colormap.f =====
design/vrc_pkg.sv
design/vrc_prep.sv
design/vrc_div_cell.sv
design/value_to_rgb_colormap.sv
dv/testbench.sv
